### rtl/wsp_pkg.sv
// Shared types and constants for the wheel speed PID controller.
// Depends on nothing; used by every module under rtl except wsp_divider.
package wsp_pkg;

   localparam int unsigned TargetWidth = 12;
   localparam int unsigned GainWidth = 32;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned QueueDepth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_TARGET = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_P_GAIN = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_I_GAIN = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_D_GAIN = 2'd3;

   localparam logic [11:0] TARGET_RESET = 12'd40;
   localparam logic [31:0] P_GAIN_RESET = 32'd587202560;
   localparam logic [31:0] I_GAIN_RESET = 32'd1678;
   localparam logic [31:0] D_GAIN_RESET = 32'd1678;

   localparam logic [11:0] SPEED_SCALE = 12'd3570;
   localparam logic [7:0] PWM_MAX = 8'd200;

   typedef struct packed {
      logic [7:0] pulse_count;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] pwm_level;
      logic signed [31:0] raw_drive;
      logic [19:0] measured_speed;
   } rsp_type;

   // Item handed from the front end to the back end: numerator and divisor.
   typedef struct packed {
      logic [19:0] speed_num;
      logic [15:0] elapsed_ms;
   } job_type;

endpackage

### rtl/wsp_front.sv
// Front end: takes a request transfer, forms pulses*3570 and queues the job.
// Depends on wsp_pkg.
module wsp_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  wsp_pkg::req_type req_data,
   output logic job_valid,
   input  logic job_take,
   output wsp_pkg::job_type job_data
);

   logic [1:0] count_ff, count_in;
   logic rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   wsp_pkg::job_type slot_ff [wsp_pkg::QueueDepth];
   logic push, pop;
   wsp_pkg::job_type new_job;

   // Classify the request into a division job.
   always_comb begin
      new_job.speed_num = 20'(req_data.pulse_count) * 20'(wsp_pkg::SPEED_SCALE);
      new_job.elapsed_ms = req_data.elapsed_ms;
   end

   assign req_stall = (count_ff == 2'(wsp_pkg::QueueDepth));
   assign push = req_valid && !req_stall;
   assign pop = job_valid && job_take;
   assign job_valid = (count_ff != 2'd0);
   assign job_data = slot_ff[rd_ptr_ff];

   // Two-entry queue pointers.
   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

### rtl/wsp_divider.sv
// Restoring divider, one quotient bit per cycle, shared by speed and D term.
// Depends on nothing.
module wsp_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [63:0] dividend,
   input  logic [39:0] divisor,
   output logic busy,
   output logic [63:0] quotient
);

   logic [6:0] step_ff, step_in;
   logic [63:0] quo_ff, quo_in;
   logic [40:0] rem_ff, rem_in;
   logic [39:0] div_ff, div_in;
   logic [40:0] trial;

   assign busy = (step_ff != 7'd0);
   assign quotient = quo_ff;

   // Shift in one dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff[39:0], quo_ff[63]};
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         step_in = 7'd64;
         quo_in = dividend;
         rem_in = 41'd0;
         div_in = divisor;
      end else if (busy) begin
         step_in = step_ff - 7'd1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 7'd0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

### rtl/wsp_back.sv
// Back end: division, error, integral, three gain terms, clamp and output.
// Depends on wsp_pkg and wsp_divider.
module wsp_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_take,
   input  wsp_pkg::job_type job_data,
   input  logic [11:0] target_speed,
   input  logic [31:0] p_gain,
   input  logic [31:0] i_gain,
   input  logic [31:0] d_gain,
   output logic rsp_valid,
   input  logic rsp_stall,
   output wsp_pkg::rsp_type rsp_data,
   output logic idle
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SPEED = 4'd1;
   localparam logic [3:0] ST_ERR = 4'd2;
   localparam logic [3:0] ST_INTEG = 4'd3;
   localparam logic [3:0] ST_MUL_P = 4'd4;
   localparam logic [3:0] ST_MUL_IH = 4'd5;
   localparam logic [3:0] ST_MUL_IL = 4'd6;
   localparam logic [3:0] ST_MUL_D = 4'd7;
   localparam logic [3:0] ST_DIV_D = 4'd8;
   localparam logic [3:0] ST_SUM = 4'd9;
   localparam logic [3:0] ST_OUT = 4'd10;

   localparam logic signed [47:0] INTEG_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] INTEG_MIN = {1'b1, {47{1'b0}}};

   logic [3:0] state_ff, state_in;
   logic signed [47:0] integ_ff, integ_in;
   logic signed [21:0] prev_err_ff, prev_err_in;
   logic signed [21:0] err_ff;
   logic [19:0] speed_ff;
   logic [15:0] elapsed_ff;
   logic [55:0] p_term_ff, d_term_ff, i_acc_ff;
   logic neg_ff;
   logic [47:0] mag_ff;
   logic [22:0] delta_keep_ff;
   logic out_full_ff;
   wsp_pkg::rsp_type out_ff;

   logic div_start, div_busy;
   logic [63:0] div_dividend, div_quotient;
   logic [39:0] div_divisor;

   // One shared 32 by 24 multiplier.
   logic [31:0] mul_a;
   logic [23:0] mul_b;
   logic [55:0] mul_p;
   assign mul_p = mul_a * mul_b;

   wsp_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .busy(div_busy), .quotient(div_quotient)
   );

   assign rsp_valid = out_full_ff;
   assign rsp_data = out_ff;
   assign idle = (state_ff == ST_IDLE) && !out_full_ff && !job_valid;

   logic signed [22:0] delta;
   logic signed [48:0] prod_ext;
   logic signed [49:0] integ_sum;
   logic signed [58:0] drive_sum;
   logic signed [58:0] p_s, d_s, i_s;
   logic [21:0] err_mag;
   logic [22:0] delta_mag;
   logic [47:0] integ_mag;

   always_comb begin
      delta = 23'(err_ff) - 23'(prev_err_ff);
      prod_ext = 49'(err_ff) * $signed({1'b0, elapsed_ff});
      integ_sum = 50'(integ_ff) + 50'(prod_ext);
      err_mag = err_ff[21] ? 22'(-err_ff) : 22'(err_ff);
      delta_mag = delta[22] ? 23'(-delta) : 23'(delta);
      integ_mag = integ_ff[47] ? 48'(-integ_ff) : 48'(integ_ff);
      p_s = err_ff[21] ? -59'(p_term_ff) : 59'(p_term_ff);
      d_s = neg_ff ? -59'(d_term_ff) : 59'(d_term_ff);
      i_s = integ_ff[47] ? -59'(i_acc_ff) : 59'(i_acc_ff);
      drive_sum = p_s + d_s + i_s;
   end

   // Sequencer over the shared divider and multiplier.
   always_comb begin
      state_in = state_ff;
      integ_in = integ_ff;
      prev_err_in = prev_err_ff;
      job_take = 1'b0;
      div_start = 1'b0;
      div_dividend = 64'(job_data.speed_num);
      div_divisor = 40'(job_data.elapsed_ms);
      mul_a = p_gain;
      mul_b = 24'(err_mag);
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               div_start = 1'b1;
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            if (!div_busy) state_in = ST_ERR;
         end
         ST_ERR: state_in = ST_INTEG;
         ST_INTEG: begin
            if (integ_sum > 50'(INTEG_MAX)) integ_in = INTEG_MAX;
            else if (integ_sum < 50'(INTEG_MIN)) integ_in = INTEG_MIN;
            else integ_in = 48'(integ_sum);
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            mul_a = p_gain;
            mul_b = 24'(err_mag);
            state_in = ST_MUL_IH;
         end
         ST_MUL_IH: begin
            mul_a = i_gain;
            mul_b = mag_ff[47:24];
            state_in = ST_MUL_IL;
         end
         ST_MUL_IL: begin
            mul_a = i_gain;
            mul_b = mag_ff[23:0];
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            mul_a = d_gain;
            mul_b = 24'(delta_keep_ff);
            state_in = ST_DIV_D;
         end
         ST_DIV_D: begin
            div_start = 1'b1;
            div_dividend = 64'(d_term_ff);
            div_divisor = {elapsed_ff, 24'd0};
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!div_busy && !out_full_ff) begin
               prev_err_in = err_ff;
               state_in = ST_OUT;
            end
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         integ_ff <= 48'sd0;
         prev_err_ff <= 22'sd0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         integ_ff <= integ_in;
         prev_err_ff <= prev_err_in;
         if (state_ff == ST_OUT) out_full_ff <= 1'b1;
         else if (out_full_ff && !rsp_stall) out_full_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: elapsed_ff <= job_data.elapsed_ms;
         ST_SPEED: begin
            speed_ff <= (elapsed_ff == 16'd0) ? 20'd0 : 20'(div_quotient);
         end
         ST_ERR: err_ff <= 22'(target_speed) - 22'(speed_ff);
         ST_INTEG: begin
            neg_ff <= delta[22];
         end
         ST_MUL_P: p_term_ff <= mul_p >> 24;
         ST_MUL_IH: i_acc_ff <= mul_p;
         ST_MUL_IL: begin
            i_acc_ff <= i_acc_ff + (mul_p >> 24);
         end
         ST_MUL_D: d_term_ff <= mul_p;
         ST_SUM: begin
            if (!div_busy) begin
               d_term_ff <= (elapsed_ff == 16'd0) ? 56'd0 : 56'(div_quotient);
            end
         end
         ST_OUT: begin
            out_ff.measured_speed <= speed_ff;
            if (drive_sum > 59'sd2147483647) out_ff.raw_drive <= 32'sh7FFFFFFF;
            else if (drive_sum < -59'sd2147483648) out_ff.raw_drive <= 32'sh80000000;
            else out_ff.raw_drive <= 32'(drive_sum);
            if (drive_sum < 59'sd0) out_ff.pwm_level <= 8'd0;
            else if (drive_sum > 59'(wsp_pkg::PWM_MAX)) out_ff.pwm_level <= wsp_pkg::PWM_MAX;
            else out_ff.pwm_level <= 8'(drive_sum);
         end
         default: begin
         end
      endcase
      // Integral magnitude is needed once the new integral is stored.
      if (state_ff == ST_MUL_P) mag_ff <= integ_mag;
      if (state_ff == ST_MUL_IL) mag_ff <= mag_ff;
   end

   // Keep the error change for the D multiply, since mag_ff carries the integral.
   always_ff @(posedge clock) begin
      if (state_ff == ST_INTEG) delta_keep_ff <= delta_mag;
   end

endmodule

### rtl/wheel_speed_pid_top.sv
// Top level of the wheel speed PID controller: CSRs, front end, back end.
// Depends on wsp_pkg, wsp_front, wsp_back.
// Each request passes through two 64-step divisions in the shared divider
// (speed, then D term) and the sequencer states around them.
// Throughput: the back end finishes one item before taking the next; a stalled response holds the back end.
// Reset: synchronous, active high; clears integral, previous error, queue.
module wheel_speed_pid_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  wsp_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output wsp_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [wsp_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   logic [11:0] target_ff;
   logic [31:0] p_gain_ff, i_gain_ff, d_gain_ff;
   logic job_valid, job_take, back_idle;
   wsp_pkg::job_type job_data;

   assign csr_ready = 1'b1;

   // Configuration register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= wsp_pkg::TARGET_RESET;
         p_gain_ff <= wsp_pkg::P_GAIN_RESET;
         i_gain_ff <= wsp_pkg::I_GAIN_RESET;
         d_gain_ff <= wsp_pkg::D_GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wsp_pkg::CSR_TARGET: target_ff <= csr_wdata[11:0];
            wsp_pkg::CSR_P_GAIN: p_gain_ff <= csr_wdata;
            wsp_pkg::CSR_I_GAIN: i_gain_ff <= csr_wdata;
            wsp_pkg::CSR_D_GAIN: d_gain_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   wsp_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .job_valid(job_valid), .job_take(job_take),
      .job_data(job_data)
   );

   wsp_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_take(job_take),
      .job_data(job_data), .target_speed(target_ff), .p_gain(p_gain_ff),
      .i_gain(i_gain_ff), .d_gain(d_gain_ff), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_data(rsp_data), .idle(back_idle)
   );

   // A response level never exceeds the clamp limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pwm_level <= wsp_pkg::PWM_MAX)
      else $error("pwm level above limit");

   // A positive raw drive above the limit must show the clamped level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.raw_drive > 32'sd200 |-> rsp_data.pwm_level == wsp_pkg::PWM_MAX)
      else $error("clamp mismatch");

   // Idle back end with an empty queue raises no response by itself.
   assert property (@(posedge clock) disable iff (reset)
      back_idle && !rsp_valid |=> !rsp_valid)
      else $error("spurious response");

endmodule
